// ===== rtl/mmh_pkg.sv =====
// Shared types and constants for the 64-bit Murmur-style hash block.
// No dependencies; used by mmh_ctrl, mmh_datapath and murmur_hash_64a.
`timescale 1ns / 1ps
`default_nettype none

package mmh_pkg;

  localparam logic [63:0] MixM    = 64'hc6a4a7935bd1e995;
  localparam int unsigned MixR    = 47;
  localparam int unsigned SeedW   = 32;
  localparam int unsigned LenW    = 31;
  localparam int unsigned BytesW  = 4;
  // steps of the split 64x64 (low half) multiply
  localparam logic [1:0]  MulLast = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MUL_LEN,
    S_SEED,
    S_BODY,
    S_MUL_K1,
    S_KMIX,
    S_MUL_K2,
    S_KXOR,
    S_MUL_H,
    S_HSTORE,
    S_TAIL,
    S_MUL_FIN,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LD_LEN,
    OP_MUL,
    OP_H_SEED,
    OP_LD_WORD,
    OP_LD_KMIX,
    OP_LD_HXK,
    OP_LD_PART,
    OP_H_PROD,
    OP_LD_FIN,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic       capture;
    op_e        op;
    logic [1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/murmur_hash_64a.sv =====
// Top level of the 64-bit Murmur-style (64A) message hash.
// Instantiates mmh_ctrl and mmh_datapath; uses mmh_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Hashes a message delivered as little-endian 64-bit words, one request per
// word, first byte in word_i[7:0]. The first request of a message carries
// total_length_i; the running hash starts as seed xor (length * M). Full
// words (word_bytes_i of 8 or more) get the multiply/shift/multiply mix,
// a word of 1 to 7 bytes has its valid bytes xored in, a word of 0 bytes
// adds nothing. The request with last_i set produces one result on hash_o
// after the finalize step; other requests produce no result. An empty
// message is one request with zero bytes and last set. The seed register
// (reset 1) is to be written by the user via seed_we_i / seed_wdata_i only
// while the block is idle; the block itself does not enforce this. A new seed
// applies from the next message start. One request is processed at a time.
// Every 64-bit product goes through a single 32x32 multiplier in three
// steps. A full word takes three products, a partial word one and an empty
// word none; the first word of a message adds the length product and the
// last word adds the finalize product. The result sits in an output
// register, so the next request is taken while it waits; a finishing
// message stalls only if the previous result has still not been taken.
module murmur_hash_64a (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        seed_we_i,
  input  wire logic [mmh_pkg::SeedW-1:0]   seed_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [63:0]                 word_i,
  input  wire logic [mmh_pkg::BytesW-1:0]  word_bytes_i,
  input  wire logic [mmh_pkg::LenW-1:0]    total_length_i,
  input  wire logic                        last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [63:0]                      hash_o
);

  mmh_pkg::dp_cmd_t    cmd;
  mmh_pkg::dp_status_t status;

  // sequencer: handshakes and op stream
  mmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // registers, shared multiplier, hash state
  mmh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_we_i      (seed_we_i),
    .seed_wdata_i   (seed_wdata_i),
    .word_i         (word_i),
    .word_bytes_i   (word_bytes_i),
    .total_length_i (total_length_i),
    .last_i         (last_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .hash_o         (hash_o)
  );

endmodule

`default_nettype wire

// ===== rtl/mmh_datapath.sv =====
// Datapath of the hash block: request registers, seed, running hash and a
// shared 32x32 multiplier that builds 64-bit products in three steps. Uses mmh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmh_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           seed_we_i,
  input  wire logic [mmh_pkg::SeedW-1:0]      seed_wdata_i,
  input  wire logic [63:0]                    word_i,
  input  wire logic [mmh_pkg::BytesW-1:0]     word_bytes_i,
  input  wire logic [mmh_pkg::LenW-1:0]       total_length_i,
  input  wire logic                           last_i,
  input  wire mmh_pkg::dp_cmd_t               cmd_i,
  output mmh_pkg::dp_status_t                 status_o,
  output logic [63:0]                         hash_o
);

  logic [mmh_pkg::SeedW-1:0]  seed_q;
  logic [63:0]                word_q;
  logic [mmh_pkg::BytesW-1:0] bytes_q;
  logic [mmh_pkg::LenW-1:0]   len_q;
  logic                       last_q;
  logic [63:0]                a_q, a_d;
  logic [63:0]                p_q, p_d;
  logic [63:0]                h_q, h_d;
  logic [63:0]                hash_q;
  logic [63:0]                part_word;
  logic [31:0]                mul_x, mul_y;
  logic [63:0]                mul_prod;

  // seed register, reset value 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mmh_pkg::SeedW'(1);
    end else if (seed_we_i) begin
      seed_q <= seed_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q  <= word_i;
      bytes_q <= word_bytes_i;
      len_q   <= total_length_i;
      last_q  <= last_i;
    end
  end

  // keep only the valid low bytes of a partial word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      part_word[8*i +: 8] = (bytes_q > mmh_pkg::BytesW'(i)) ? word_q[8*i +: 8] : 8'h00;
    end
  end

  // low 64 bits of a*M = aL*ML + ((aL*MH + aH*ML) << 32)
  assign mul_x    = (cmd_i.step == mmh_pkg::MulLast) ? a_q[63:32] : a_q[31:0];
  assign mul_y    = (cmd_i.step == 2'd1) ? mmh_pkg::MixM[63:32] : mmh_pkg::MixM[31:0];
  assign mul_prod = 64'(mul_x) * 64'(mul_y);

  always_comb begin
    a_d = a_q;
    p_d = p_q;
    h_d = h_q;
    unique case (cmd_i.op)
      mmh_pkg::OP_NONE:    ;
      mmh_pkg::OP_LD_LEN:  a_d = {{(64-mmh_pkg::LenW){1'b0}}, len_q};
      mmh_pkg::OP_MUL: begin
        if (cmd_i.step == 2'd0) begin
          p_d = mul_prod;
        end else begin
          p_d = p_q + {mul_prod[31:0], 32'h0};
        end
      end
      mmh_pkg::OP_H_SEED:  h_d = {{(64-mmh_pkg::SeedW){1'b0}}, seed_q} ^ p_q;
      mmh_pkg::OP_LD_WORD: a_d = word_q;
      mmh_pkg::OP_LD_KMIX: a_d = p_q ^ (p_q >> mmh_pkg::MixR);
      mmh_pkg::OP_LD_HXK:  a_d = h_q ^ p_q;
      mmh_pkg::OP_LD_PART: a_d = h_q ^ part_word;
      mmh_pkg::OP_H_PROD:  h_d = p_q;
      mmh_pkg::OP_LD_FIN:  a_d = h_q ^ (h_q >> mmh_pkg::MixR);
      mmh_pkg::OP_OUT:     ;
      default:             ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
    h_q <= h_d;
    if (cmd_i.op == mmh_pkg::OP_OUT) begin
      hash_q <= p_q ^ (p_q >> mmh_pkg::MixR);
    end
  end

  assign status_o.full  = bytes_q[3];
  assign status_o.empty = (bytes_q == '0);
  assign status_o.last  = last_q;
  assign hash_o         = hash_q;

endmodule

`default_nettype wire

// ===== rtl/mmh_ctrl.sv =====
// Sequencer of the hash block: request/result handshakes, message tracking
// and the op stream for mmh_datapath. Uses mmh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmh_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire mmh_pkg::dp_status_t  status_i,
  output mmh_pkg::dp_cmd_t          cmd_o
);

  mmh_pkg::state_e state_q, state_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            in_msg_q, in_msg_d;
  logic            out_valid_q, out_valid_d;
  logic            mul_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmh_pkg::S_IDLE;
      cnt_q       <= '0;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign mul_done = (cnt_q == mmh_pkg::MulLast);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_msg_d    = in_msg_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '{capture: 1'b0, op: mmh_pkg::OP_NONE, step: cnt_q};
    in_ready_o  = 1'b0;
    unique case (state_q)
      mmh_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = mmh_pkg::S_START;
        end
      end
      mmh_pkg::S_START: begin
        if (!in_msg_q) begin
          cmd_o.op = mmh_pkg::OP_LD_LEN;
          state_d  = mmh_pkg::S_MUL_LEN;
        end else begin
          state_d  = mmh_pkg::S_BODY;
        end
      end
      mmh_pkg::S_MUL_LEN, mmh_pkg::S_MUL_K1, mmh_pkg::S_MUL_K2,
      mmh_pkg::S_MUL_H, mmh_pkg::S_MUL_FIN: begin
        cmd_o.op = mmh_pkg::OP_MUL;
        if (mul_done) begin
          cnt_d = '0;
          unique case (state_q)
            mmh_pkg::S_MUL_LEN: state_d = mmh_pkg::S_SEED;
            mmh_pkg::S_MUL_K1:  state_d = mmh_pkg::S_KMIX;
            mmh_pkg::S_MUL_K2:  state_d = mmh_pkg::S_KXOR;
            mmh_pkg::S_MUL_H:   state_d = mmh_pkg::S_HSTORE;
            default:            state_d = mmh_pkg::S_OUT;
          endcase
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      mmh_pkg::S_SEED: begin
        cmd_o.op = mmh_pkg::OP_H_SEED;
        in_msg_d = 1'b1;
        state_d  = mmh_pkg::S_BODY;
      end
      mmh_pkg::S_BODY: begin
        if (status_i.full) begin
          cmd_o.op = mmh_pkg::OP_LD_WORD;
          state_d  = mmh_pkg::S_MUL_K1;
        end else if (!status_i.empty) begin
          cmd_o.op = mmh_pkg::OP_LD_PART;
          state_d  = mmh_pkg::S_MUL_H;
        end else begin
          state_d  = mmh_pkg::S_TAIL;
        end
      end
      mmh_pkg::S_KMIX: begin
        cmd_o.op = mmh_pkg::OP_LD_KMIX;
        state_d  = mmh_pkg::S_MUL_K2;
      end
      mmh_pkg::S_KXOR: begin
        cmd_o.op = mmh_pkg::OP_LD_HXK;
        state_d  = mmh_pkg::S_MUL_H;
      end
      mmh_pkg::S_HSTORE: begin
        cmd_o.op = mmh_pkg::OP_H_PROD;
        state_d  = mmh_pkg::S_TAIL;
      end
      mmh_pkg::S_TAIL: begin
        if (status_i.last) begin
          cmd_o.op = mmh_pkg::OP_LD_FIN;
          state_d  = mmh_pkg::S_MUL_FIN;
        end else begin
          state_d  = mmh_pkg::S_IDLE;
        end
      end
      mmh_pkg::S_OUT: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = mmh_pkg::OP_OUT;
          out_valid_d = 1'b1;
          in_msg_d    = 1'b0;
          state_d     = mmh_pkg::S_IDLE;
        end
      end
      default: state_d = mmh_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while previous one in flight");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("multiply step counter out of range");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(out_valid_q) || $past(out_ready_i)) && out_valid_q
      |-> $past(state_q) == mmh_pkg::S_OUT)
    else $error("result loaded outside finalize");

  a_out_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mmh_pkg::S_OUT && out_valid_q && !out_ready_i)
      |=> state_q == mmh_pkg::S_OUT)
    else $error("finalize overwrote a pending result");

  a_mul_count_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mmh_pkg::S_IDLE) |-> cnt_q == 2'd0)
    else $error("multiply step counter left dirty");
`endif

endmodule

`default_nettype wire

// ===== tb/murmur_hash_64a_tb.sv =====
// Self-checking testbench for murmur_hash_64a, the 64-bit word-stream Murmur hash.
// Depends on mmh_pkg (port widths and mix constants) and the murmur_hash_64a RTL, nothing else.
`timescale 1ns / 1ps

module murmur_hash_64a_tb;

  localparam int unsigned CycleLimit   = 600000; // generous timeout
  localparam int unsigned SettleCycles = 40;     // outlasts the worst case, a first+full+last request
  localparam int unsigned MaxShown     = 20;     // mismatch lines printed, all are counted
  localparam int unsigned HoldOffLen   = 400;    // long receiver hold-off for back-pressure

  // one word request as the sender presents it
  typedef struct {
    logic [63:0]                word;
    logic [mmh_pkg::BytesW-1:0] nbytes;
    logic [mmh_pkg::LenW-1:0]   len;
    logic                       last;
  } word_req_t;

  // ---------------------------------------------------------------------------
  // DUT ports, every input known from time zero
  // ---------------------------------------------------------------------------
  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        seed_we_i      = 1'b0;
  logic [mmh_pkg::SeedW-1:0]   seed_wdata_i   = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_ready_o;
  logic [63:0]                 word_i         = '0;
  logic [mmh_pkg::BytesW-1:0]  word_bytes_i   = '0;
  logic [mmh_pkg::LenW-1:0]    total_length_i = '0;
  logic                        last_i         = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i    = 1'b0;
  logic [63:0]                 hash_o;

  murmur_hash_64a i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_we_i      (seed_we_i),
    .seed_wdata_i   (seed_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .word_i         (word_i),
    .word_bytes_i   (word_bytes_i),
    .total_length_i (total_length_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hash_o         (hash_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Hash predictor: own copy of seed, running hash and message-open flag.
  // Runs on every accepted request; a request with last set yields one hash.
  // ---------------------------------------------------------------------------
  logic [mmh_pkg::SeedW-1:0] seed_shadow = 32'd1;  // seed resets to 1
  logic [63:0]               run_hash    = '0;
  logic                      msg_open    = 1'b0;
  logic [63:0]               hashes_due[$];
  word_req_t                 words_to_send[$];

  int unsigned n_queued, n_accepted, n_checked, n_errors, n_msgs, n_seeds;

  function automatic void absorb_word(input logic [63:0] w,
                                      input logic [mmh_pkg::BytesW-1:0] nb,
                                      input logic [mmh_pkg::LenW-1:0] len,
                                      input logic lst);
    logic [63:0] h;
    logic [63:0] k;
    logic [63:0] mask;
    // seed is latched only at message start; a later write waits for the next one
    if (!msg_open) begin
      run_hash = {32'd0, seed_shadow} ^ (64'(len) * mmh_pkg::MixM);
      msg_open = 1'b1;
    end
    h = run_hash;
    if (nb >= 4'd8) begin
      // 9..15 bytes count as a full word
      k = w * mmh_pkg::MixM;
      k = k ^ (k >> mmh_pkg::MixR);
      k = k * mmh_pkg::MixM;
      h = (h ^ k) * mmh_pkg::MixM;
    end else if (nb != '0) begin
      // partial word, upper bytes dropped; legal mid-message too
      mask = (64'd1 << (8 * nb)) - 64'd1;
      h = (h ^ (w & mask)) * mmh_pkg::MixM;
    end
    run_hash = h;
    if (lst) begin
      h = h ^ (h >> mmh_pkg::MixR);
      h = h * mmh_pkg::MixM;
      h = h ^ (h >> mmh_pkg::MixR);
      hashes_due.push_back(h);
      run_hash = '0;
      msg_open = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (n_errors < MaxShown)
      $display("[%0t] MISMATCH %s: got %016h, expected %016h", $time, what, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps; valid holds until accepted.
  // ---------------------------------------------------------------------------
  int unsigned burst_left, gap_left;
  word_req_t   drv_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        absorb_word(word_i, word_bytes_i, total_length_i, last_i);
        n_accepted++;
      end
      // free to change the bus only when nothing is waiting on it
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (words_to_send.size() != 0) begin
          drv_req = words_to_send.pop_front();
          word_i         <= drv_req.word;
          word_bytes_i   <= drv_req.nbytes;
          total_length_i <= drv_req.len;
          last_i         <= drv_req.last;
          in_valid_i     <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // mix of long gap-free runs and choppy traffic
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(1, 4);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches between modes; one long hold-off on demand
  // ---------------------------------------------------------------------------
  logic        hold_arm  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left, mode_left, rx_mode;
  logic [31:0] stall_pat;
  logic        rdy_nxt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        rdy_nxt = 1'b0;
      end else if (hold_arm && !hold_done) begin
        hold_left = HoldOffLen;
        hold_done = 1'b1;
        rdy_nxt   = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
          stall_pat = $urandom;
        end
        mode_left--;
        case (rx_mode)
          0: rdy_nxt = 1'b1;                              // no stalls
          1: rdy_nxt = ($urandom_range(0, 1) != 0);       // coin flip
          2: begin                                        // rotating fixed pattern
            rdy_nxt   = stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[31:1]};
          end
          default: rdy_nxt = ($urandom_range(0, 7) == 0); // mostly stalled
        endcase
      end
      out_ready_i <= rdy_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted hash against the oldest prediction
  // ---------------------------------------------------------------------------
  logic [63:0] want_hash;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hashes_due.size() == 0) begin
        report_mismatch("hash with no message pending", hash_o, '0);
      end else begin
        want_hash = hashes_due.pop_front();
        if (hash_o !== want_hash) report_mismatch("hash", hash_o, want_hash);
        n_checked++;
      end
    end
  end

  // watchdog
  int unsigned cycle_count;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d hashes outstanding", cycle_count,
               hashes_due.size());
      $display("murmur_hash_64a regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic push_word(input logic [63:0] w, input int unsigned nb,
                           input logic [mmh_pkg::LenW-1:0] len, input logic lst);
    word_req_t r;
    r.word   = w;
    r.nbytes = nb[mmh_pkg::BytesW-1:0];
    r.len    = len;
    r.last   = lst;
    words_to_send.push_back(r);
    n_queued++;
    if (lst) n_msgs++;
  endtask

  // well-formed message: full words then a 1..7 byte tail; length on the first
  // request only, the length field of later requests is junk and must be ignored
  task automatic queue_message(input int unsigned nbytes);
    int unsigned nfull;
    int unsigned tail;
    int unsigned i;
    logic [mmh_pkg::LenW-1:0] lenf;
    nfull = nbytes / 8;
    tail  = nbytes % 8;
    if (nbytes == 0) begin
      push_word(rand_word(), 0, '0, 1'b1);
    end else begin
      for (i = 0; i < nfull; i++) begin
        lenf = (i == 0) ? nbytes[mmh_pkg::LenW-1:0] : mmh_pkg::LenW'($urandom);
        push_word(rand_word(), 8, lenf, (tail == 0) && (i == nfull - 1));
      end
      if (tail != 0) begin
        lenf = (nfull == 0) ? nbytes[mmh_pkg::LenW-1:0] : mmh_pkg::LenW'($urandom);
        push_word(rand_word(), tail, lenf, 1'b1);
      end
    end
  endtask

  // broken message: any byte count 0..15 anywhere, length unrelated to content
  task automatic queue_noise_message();
    int unsigned n;
    int unsigned i;
    logic [mmh_pkg::LenW-1:0] lenf;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      lenf = ($urandom_range(0, 1) != 0) ? mmh_pkg::LenW'($urandom)
                                         : mmh_pkg::LenW'($urandom_range(0, 60));
      push_word(rand_word(), $urandom_range(0, 15), lenf, i == n - 1);
    end
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned start;
    int unsigned r;
    start = n_queued;
    while (n_queued - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        // mostly short messages, a few long ones
        r = $urandom_range(0, 99);
        if (r < 85)      queue_message($urandom_range(0, 40));
        else if (r < 97) queue_message($urandom_range(41, 120));
        else             queue_message($urandom_range(121, 400));
      end else begin
        queue_noise_message();
      end
    end
  endtask

  // corner cases of the hash datapath
  task automatic queue_directed();
    logic [63:0] ones;
    ones = '1;
    push_word(rand_word(), 0, 31'd0, 1'b1);             // empty message
    push_word(ones, 1, 31'd1, 1'b1);                    // one byte, junk above
    push_word(ones, 7, 31'd7, 1'b1);                    // seven-byte tail
    push_word('0, 8, 31'd8, 1'b1);                      // zero word
    push_word(ones, 8, 31'd8, 1'b1);                    // all-ones word
    push_word(rand_word(), 8, '1, 1'b1);                // max length, 8 bytes sent
    push_word(rand_word(), 15, 31'd8, 1'b1);            // byte count above eight
    push_word(rand_word(), 9, 31'd16, 1'b0);
    push_word(rand_word(), 8, 31'd0, 1'b1);
    push_word(rand_word(), 8, 31'd16, 1'b0);            // zero bytes mid-message
    push_word(rand_word(), 0, '1, 1'b0);
    push_word(rand_word(), 8, 31'd0, 1'b1);
    push_word(rand_word(), 3, 31'd11, 1'b0);            // partial word mid-message
    push_word(ones, 8, 31'd0, 1'b1);
    push_word(rand_word(), 8, 31'd19, 1'b0);            // 16 + 3 bytes
    push_word(rand_word(), 8, '1, 1'b0);
    push_word(rand_word(), 3, 31'h2aaaaaaa, 1'b1);
    push_word(rand_word(), 8, 31'd10, 1'b0);            // later length field ignored
    push_word(ones, 2, '1, 1'b1);
    push_word(rand_word(), 0, 31'd5, 1'b1);             // empty with nonzero length
  endtask

  // wait for the sender to drain and every hash to come back, then let the
  // block settle (a request without last gives no sign when it is done);
  // sampled at the falling edge so the driver's updates have landed
  task automatic wait_idle();
    while (words_to_send.size() != 0 || in_valid_i || hashes_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [mmh_pkg::SeedW-1:0] v);
    @(posedge clk_i);
    seed_we_i    <= 1'b1;
    seed_wdata_i <= v;
    seed_shadow  = v;
    n_seeds++;
    @(posedge clk_i);
    seed_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int unsigned k;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset seed value first
    queue_directed();
    wait_idle();

    // seed extremes
    write_seed('0);
    queue_random(250);
    wait_idle();

    write_seed('1);
    queue_directed();
    queue_random(230);
    wait_idle();

    // back-pressure: receiver holds off while short messages keep coming
    write_seed($urandom);
    @(negedge clk_i);
    hold_arm = 1'b1;
    for (k = 0; k < 150; k++) queue_message($urandom_range(0, 16));
    wait_idle();

    // seed written mid-message: the open message keeps its starting seed
    @(negedge clk_i);
    push_word(rand_word(), 8, 31'd20, 1'b0);
    push_word(rand_word(), 8, '1, 1'b0);
    wait_idle();
    write_seed($urandom);
    push_word(rand_word(), 4, '0, 1'b1);
    wait_idle();

    for (k = 0; k < 3; k++) begin
      write_seed($urandom);
      queue_random(200);
      wait_idle();
    end

    $display("covered %0d requests in %0d messages under %0d seed writes",
             n_accepted, n_msgs, n_seeds);
    $display("%0d hashes compared, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("murmur_hash_64a regression: pass");
    end else begin
      $display("murmur_hash_64a regression: fail");
    end
    $finish;
  end

endmodule

// ===== murmur_hash_64a.f =====
rtl/mmh_pkg.sv
rtl/mmh_datapath.sv
rtl/mmh_ctrl.sv
rtl/murmur_hash_64a.sv
tb/murmur_hash_64a_tb.sv
